### hw/rtl/gtl_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// gtl_pkg
// Shared types, constants and table functions for the Gregorian to lunar
// date converter: the lunar year ROM, month lengths and result layout.
// ============================================================================
package gtl_pkg;

    // Date range and offsets
    localparam int FIRST_YEAR      = 1939;
    localparam int LAST_GREG_YEAR  = 2041;
    localparam int NEW_YEAR_OFFSET = 48;
    localparam int ROM_SIZE        = 111;
    localparam int TABLE_YEARS_DEF = 103;

    // Field and datapath widths
    localparam int GYEAR_W  = 12;
    localparam int GMONTH_W = 4;
    localparam int GDAY_W   = 5;
    localparam int STATUS_W = 2;
    localparam int LYEAR_W  = 11;
    localparam int LMONTH_W = 4;
    localparam int LDAY_W   = 5;
    localparam int DAYS_W   = 16;
    localparam int IDX_W    = $clog2(ROM_SIZE);
    localparam int WORD_W   = 20;
    localparam int YLEN_W   = 9;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

    // Shared arithmetic unit operation
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    // One result word as it leaves the sequencer
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LYEAR_W-1:0]  lunar_year;
        logic [LMONTH_W-1:0] lunar_month;
        logic [LDAY_W-1:0]   lunar_day;
        logic                is_leap_month;
    } lunar_res_t;

    // Lunar year words, one per year starting at the first lunar year.
    // Bit (16 - m) set: month m has 30 days. Bits 3..0: leap month number.
    // Bit 16 set: the leap month has 30 days.
    localparam logic [WORD_W-1:0] LUNAR_ROM [ROM_SIZE] = '{
        20'h0c950,
        20'h0d4a0, 20'h1d8a6, 20'h0b550, 20'h056a0, 20'h1a5b4,
        20'h025d0, 20'h092d0, 20'h0d2b2, 20'h0a950, 20'h0b557,
        20'h06ca0, 20'h0b550, 20'h15355, 20'h04da0, 20'h0a5d0,
        20'h14573, 20'h052d0, 20'h0a9a8, 20'h0e950, 20'h06aa0,
        20'h0aea6, 20'h0ab50, 20'h04b60, 20'h0aae4, 20'h0a570,
        20'h05260, 20'h0f263, 20'h0d950, 20'h05b57, 20'h056a0,
        20'h096d0, 20'h04dd5, 20'h04ad0, 20'h0a4d0, 20'h0d4d4,
        20'h0d250, 20'h0d558, 20'h0b540, 20'h0b5a0, 20'h195a6,
        20'h095b0, 20'h049b0, 20'h0a974, 20'h0a4b0, 20'h0b27a,
        20'h06a50, 20'h06d40, 20'h0af46, 20'h0ab60, 20'h09570,
        20'h04af5, 20'h04970, 20'h064b0, 20'h074a3, 20'h0ea50,
        20'h06b58, 20'h055c0, 20'h0ab60, 20'h096d5, 20'h092e0,
        20'h0c960, 20'h0d954, 20'h0d4a0, 20'h0da50, 20'h07552,
        20'h056a0, 20'h0abb7, 20'h025d0, 20'h092d0, 20'h0cab5,
        20'h0a950, 20'h0b4a0, 20'h0baa4, 20'h0ad50, 20'h055d9,
        20'h04ba0, 20'h0a5b0, 20'h15176, 20'h052b0, 20'h0a930,
        20'h07954, 20'h06aa0, 20'h0ad50, 20'h05b52, 20'h04b60,
        20'h0a6e6, 20'h0a4e0, 20'h0d260, 20'h0ea65, 20'h0d530,
        20'h05aa0, 20'h076a3, 20'h096d0, 20'h04bd7, 20'h04ad0,
        20'h0a4d0, 20'h1d0b6, 20'h0d250, 20'h0d520, 20'h0dd45,
        20'h0b5a0, 20'h056d0, 20'h055b2, 20'h049b0, 20'h0a577,
        20'h0a4b0, 20'h0aa50, 20'h1b255, 20'h06d20, 20'h0ada0
    };

    // ROM lookup; indexes past the table read as zero.
    function automatic logic [WORD_W-1:0] rom_word(input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] word;
        word = '0;
        if (int'(idx) < ROM_SIZE) begin
            word = LUNAR_ROM[idx];
        end
        return word;
    endfunction

    // Length of an ordinary lunar month m (1..12).
    function automatic logic [LDAY_W-1:0] lunar_month_days(input logic [WORD_W-1:0] word,
                                                           input logic [LMONTH_W-1:0] m);
        logic [4:0] bit_idx;
        bit_idx = 5'd16 - {1'b0, m};
        return 5'd29 + {4'd0, word[bit_idx]};
    endfunction

    // Length of the leap month of a year.
    function automatic logic [LDAY_W-1:0] leap_month_days(input logic [WORD_W-1:0] word);
        return 5'd29 + {4'd0, word[16]};
    endfunction

    // Length of a whole lunar year: twelve months of 29 or 30 days plus the
    // leap month where there is one.
    function automatic logic [YLEN_W-1:0] lunar_year_days(input logic [WORD_W-1:0] word);
        logic [YLEN_W-1:0] total;
        total = 9'd348;
        for (int b = 4; b <= 15; b++) begin
            total = total + {8'd0, word[b]};
        end
        if (word[3:0] != 4'd0) begin
            total = total + {4'd0, leap_month_days(word)};
        end
        return total;
    endfunction

    // Length of a Gregorian month; leap selects 29 days for February.
    function automatic logic [GDAY_W-1:0] greg_month_days(input logic [GMONTH_W-1:0] m,
                                                          input logic leap);
        logic [GDAY_W-1:0] n;
        unique case (m)
            4'd2:                     n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  n = 5'd30;
            default:                  n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

### hw/rtl/gtl_alu.sv
`timescale 1ns / 1ps
// ============================================================================
// gtl_alu
// Shared day-count adder/subtractor with an unsigned less-or-equal compare.
// Every day accumulation and every year or month step goes through it.
// ============================================================================
module gtl_alu (
    input  gtl_pkg::alu_op_t            op,
    input  logic [gtl_pkg::DAYS_W-1:0]  a,
    input  logic [gtl_pkg::DAYS_W-1:0]  b,
    output logic [gtl_pkg::DAYS_W-1:0]  result,
    output logic                        a_le_b
);

    // One adder serves both directions.
    always_comb begin
        unique case (op)
            gtl_pkg::ALU_ADD: result = a + b;
            gtl_pkg::ALU_SUB: result = a - b;
            default:          result = a + b;
        endcase
    end

    // Compare used to decide whether the remaining days fit in a year or month.
    assign a_le_b = (a <= b);

endmodule

### hw/rtl/gtl_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// gtl_ctrl
// Sequencer of the converter. It checks the date, counts the days since the
// first Gregorian year, then walks the lunar ROM year by year and month by
// month, all through one shared adder.
// ============================================================================
module gtl_ctrl #(
    parameter int TABLE_YEARS = gtl_pkg::TABLE_YEARS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [gtl_pkg::GYEAR_W-1:0]   greg_year,
    input  logic [gtl_pkg::GMONTH_W-1:0]  greg_month,
    input  logic [gtl_pkg::GDAY_W-1:0]    greg_day,
    output logic                          idle,
    output logic                          res_valid,
    input  logic                          res_ready,
    output gtl_pkg::lunar_res_t           res
);

    localparam int DW = gtl_pkg::DAYS_W;
    localparam int IW = gtl_pkg::IDX_W;
    localparam int YW = gtl_pkg::LYEAR_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_YEARS,
        S_MONTHS,
        S_DAY,
        S_OFFSET,
        S_LYEAR,
        S_LMON,
        S_LLEAP,
        S_DONE
    } state_t;

    state_t                           state_reg, state_next;
    logic [gtl_pkg::GYEAR_W-1:0]      y_reg, y_next;
    logic [gtl_pkg::GMONTH_W-1:0]     mo_reg, mo_next;
    logic [gtl_pkg::GDAY_W-1:0]       d_reg, d_next;
    logic [DW-1:0]                    days_reg, days_next;
    logic [YW-1:0]                    yr_reg, yr_next;
    logic [IW-1:0]                    idx_reg, idx_next;
    logic [gtl_pkg::LMONTH_W-1:0]     m_reg, m_next;
    logic [gtl_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [gtl_pkg::LMONTH_W-1:0]     lm_reg, lm_next;
    logic [gtl_pkg::LDAY_W-1:0]       ld_reg, ld_next;
    logic                             leap_reg, leap_next;

    gtl_pkg::alu_op_t                 alu_op;
    logic [DW-1:0]                    alu_b;
    logic [DW-1:0]                    alu_res;
    logic                             alu_le;

    logic [gtl_pkg::WORD_W-1:0]       word;
    logic [gtl_pkg::YLEN_W-1:0]       ylen;
    logic [gtl_pkg::LDAY_W-1:0]       mdays;
    logic [gtl_pkg::LDAY_W-1:0]       ldays;
    logic                             yr_leap;
    logic                             y_leap;
    logic                             date_ok;

    // Within 1939..2041 the only century year is 2000, itself a leap year,
    // so divisibility by four decides leap years.
    assign yr_leap = (yr_reg[1:0] == 2'b00);
    assign y_leap  = (y_reg[1:0] == 2'b00);

    // Current lunar year word and the lengths derived from it.
    assign word  = gtl_pkg::rom_word(idx_reg);
    assign ylen  = gtl_pkg::lunar_year_days(word);
    assign mdays = gtl_pkg::lunar_month_days(word, m_reg);
    assign ldays = gtl_pkg::leap_month_days(word);

    // Range check on the captured date.
    assign date_ok = (int'(y_reg) >= gtl_pkg::FIRST_YEAR) &&
                     (int'(y_reg) <= gtl_pkg::LAST_GREG_YEAR) &&
                     (mo_reg >= 4'd1) && (mo_reg <= 4'd12) &&
                     (d_reg != 5'd0) &&
                     (d_reg <= gtl_pkg::greg_month_days(mo_reg, y_leap));

    // Operand selection for the shared adder.
    always_comb begin
        alu_op = gtl_pkg::ALU_SUB;
        alu_b  = '0;
        unique case (state_reg)
            S_YEARS: begin
                alu_op = gtl_pkg::ALU_ADD;
                alu_b  = yr_leap ? DW'(366) : DW'(365);
            end
            S_MONTHS: begin
                alu_op = gtl_pkg::ALU_ADD;
                alu_b  = DW'(gtl_pkg::greg_month_days(m_reg, y_leap));
            end
            S_DAY: begin
                alu_op = gtl_pkg::ALU_ADD;
                alu_b  = DW'(d_reg - 5'd1);
            end
            S_OFFSET: alu_b = DW'(gtl_pkg::NEW_YEAR_OFFSET);
            S_LYEAR:  alu_b = DW'(ylen);
            S_LMON:   alu_b = DW'(mdays);
            S_LLEAP:  alu_b = DW'(ldays);
            default:  alu_b = '0;
        endcase
    end

    gtl_alu u_alu (
        .op     (alu_op),
        .a      (days_reg),
        .b      (alu_b),
        .result (alu_res),
        .a_le_b (alu_le)
    );

    // Sequencer next-state and datapath updates.
    always_comb begin
        state_next  = state_reg;
        y_next      = y_reg;
        mo_next     = mo_reg;
        d_next      = d_reg;
        days_next   = days_reg;
        yr_next     = yr_reg;
        idx_next    = idx_reg;
        m_next      = m_reg;
        status_next = status_reg;
        lm_next     = lm_reg;
        ld_next     = ld_reg;
        leap_next   = leap_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    y_next      = greg_year;
                    mo_next     = greg_month;
                    d_next      = greg_day;
                    status_next = gtl_pkg::STATUS_OK;
                    lm_next     = '0;
                    ld_next     = '0;
                    leap_next   = 1'b0;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                days_next = '0;
                yr_next   = YW'(gtl_pkg::FIRST_YEAR);
                m_next    = 4'd1;
                if (date_ok) begin
                    state_next = S_YEARS;
                end else begin
                    status_next = gtl_pkg::STATUS_INVALID;
                    state_next  = S_DONE;
                end
            end
            // Whole Gregorian years before the input year.
            S_YEARS: begin
                if ({1'b0, yr_reg} < y_reg) begin
                    days_next = alu_res;
                    yr_next   = yr_reg + 1'b1;
                end else begin
                    state_next = S_MONTHS;
                end
            end
            // Whole months before the input month.
            S_MONTHS: begin
                if (m_reg < mo_reg) begin
                    days_next = alu_res;
                    m_next    = m_reg + 1'b1;
                end else begin
                    state_next = S_DAY;
                end
            end
            S_DAY: begin
                days_next  = alu_res;
                state_next = S_OFFSET;
            end
            // Dates up to and including the offset precede the first lunar year.
            S_OFFSET: begin
                idx_next = '0;
                yr_next  = YW'(gtl_pkg::FIRST_YEAR);
                if (alu_le) begin
                    status_next = gtl_pkg::STATUS_RANGE;
                    state_next  = S_DONE;
                end else begin
                    days_next  = alu_res;
                    state_next = S_LYEAR;
                end
            end
            // Skip whole lunar years.
            S_LYEAR: begin
                m_next = 4'd1;
                if (int'(idx_reg) >= TABLE_YEARS) begin
                    status_next = gtl_pkg::STATUS_RANGE;
                    state_next  = S_DONE;
                end else if (alu_le) begin
                    state_next = S_LMON;
                end else begin
                    days_next = alu_res;
                    idx_next  = idx_reg + 1'b1;
                    yr_next   = yr_reg + 1'b1;
                end
            end
            // Ordinary month; a leap month follows when its number matches.
            S_LMON: begin
                if (alu_le) begin
                    lm_next    = m_reg;
                    ld_next    = days_reg[gtl_pkg::LDAY_W-1:0];
                    state_next = S_DONE;
                end else begin
                    days_next = alu_res;
                    if (word[3:0] == m_reg) begin
                        state_next = S_LLEAP;
                    end else if (m_reg == 4'd12) begin
                        status_next = gtl_pkg::STATUS_RANGE;
                        state_next  = S_DONE;
                    end else begin
                        m_next = m_reg + 1'b1;
                    end
                end
            end
            // Leap month, including its last day.
            S_LLEAP: begin
                if (alu_le) begin
                    lm_next    = m_reg;
                    ld_next    = days_reg[gtl_pkg::LDAY_W-1:0];
                    leap_next  = 1'b1;
                    state_next = S_DONE;
                end else begin
                    days_next = alu_res;
                    if (m_reg == 4'd12) begin
                        status_next = gtl_pkg::STATUS_RANGE;
                        state_next  = S_DONE;
                    end else begin
                        m_next     = m_reg + 1'b1;
                        state_next = S_LMON;
                    end
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        y_reg      <= y_next;
        mo_reg     <= mo_next;
        d_reg      <= d_next;
        days_reg   <= days_next;
        yr_reg     <= yr_next;
        idx_reg    <= idx_next;
        m_reg      <= m_next;
        status_reg <= status_next;
        lm_reg     <= lm_next;
        ld_reg     <= ld_next;
        leap_reg   <= leap_next;
    end

    // Result: every field but the status is zero unless the conversion succeeded.
    always_comb begin
        res.status        = status_reg;
        res.lunar_year    = (status_reg == gtl_pkg::STATUS_OK) ? yr_reg : '0;
        res.lunar_month   = (status_reg == gtl_pkg::STATUS_OK) ? lm_reg : '0;
        res.lunar_day     = (status_reg == gtl_pkg::STATUS_OK) ? ld_reg : '0;
        res.is_leap_month = (status_reg == gtl_pkg::STATUS_OK) ? leap_reg : 1'b0;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

endmodule

### hw/rtl/gregorian_to_lunar_date.sv
`timescale 1ns / 1ps
// ============================================================================
// gregorian_to_lunar_date
// Converts a Gregorian date (1939..2041) to a lunar year, month, day and
// leap-month flag, with a status for invalid or out-of-table dates.
// ============================================================================
//
// Channel   Direction  Handshake           Word
// s_        in         s_valid / s_ready   greg_year, greg_month, greg_day
// m_        out        m_valid / m_ready   status, lunar_year, lunar_month,
//                                          lunar_day, is_leap_month
//
// The shared adder adds one Gregorian year or month per cycle, then
// subtracts one lunar year or month per cycle, so the time for one word
// grows with the input year.
// s_ready is high only while the sequencer is idle; one word is in flight.
// A finished word sits in the output register; the sequencer waits only if
// that register is full and not being drained when the next result is ready.
// aresetn is synchronous and active low; there is no clearing pass.
//
module gregorian_to_lunar_date #(
    parameter int TABLE_YEARS = gtl_pkg::TABLE_YEARS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gtl_pkg::GYEAR_W-1:0]   s_greg_year,
    input  logic [gtl_pkg::GMONTH_W-1:0]  s_greg_month,
    input  logic [gtl_pkg::GDAY_W-1:0]    s_greg_day,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gtl_pkg::STATUS_W-1:0]  m_status,
    output logic [gtl_pkg::LYEAR_W-1:0]   m_lunar_year,
    output logic [gtl_pkg::LMONTH_W-1:0]  m_lunar_month,
    output logic [gtl_pkg::LDAY_W-1:0]    m_lunar_day,
    output logic                          m_is_leap_month
);

    logic                 idle;
    logic                 res_valid;
    logic                 res_ready;
    gtl_pkg::lunar_res_t  res;
    logic                 load;

    logic                 out_valid_reg, out_valid_next;
    gtl_pkg::lunar_res_t  out_word_reg, out_word_next;

    assign s_ready = idle;

    gtl_ctrl #(
        .TABLE_YEARS (TABLE_YEARS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_valid && s_ready),
        .greg_year  (s_greg_year),
        .greg_month (s_greg_month),
        .greg_day   (s_greg_day),
        .idle       (idle),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: takes a result when empty or being drained.
    assign res_ready = !out_valid_reg || m_ready;
    assign load      = res_valid && res_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (load) begin
            out_valid_next = 1'b1;
            out_word_next  = res;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_word_reg <= out_word_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_word_reg.status;
    assign m_lunar_year    = out_word_reg.lunar_year;
    assign m_lunar_month   = out_word_reg.lunar_month;
    assign m_lunar_day     = out_word_reg.lunar_day;
    assign m_is_leap_month = out_word_reg.is_leap_month;

`ifndef ASSERT_OFF
    // An accepted word makes the sequencer busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a conversion is running");

    // A successful conversion lands on a real lunar month and day.
    a_ok_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == gtl_pkg::STATUS_OK)) |->
        ((m_lunar_month >= 4'd1) && (m_lunar_month <= 4'd12) &&
         (m_lunar_day >= 5'd1) && (m_lunar_day <= 5'd30)))
        else $error("lunar month or day out of range on a good result");

    // A failed conversion carries zero fields.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != gtl_pkg::STATUS_OK)) |->
        ((m_lunar_year == '0) && (m_lunar_month == '0) &&
         (m_lunar_day == '0) && !m_is_leap_month))
        else $error("nonzero fields on a failed result");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_status == gtl_pkg::STATUS_OK) ||
                     (m_status == gtl_pkg::STATUS_INVALID) ||
                     (m_status == gtl_pkg::STATUS_RANGE)))
        else $error("undefined status code");
`endif

endmodule

### tb/sv/tb_gregorian_to_lunar_date.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_gregorian_to_lunar_date
// Self-checking bench for the Gregorian to lunar date converter. A short
// table of directed dates covers the range limits, malformed dates, the days
// around the first lunar new year and days inside leap months. Random dates
// follow, mostly well-formed with some raw noise. Each result word is compared
// field by field with its typed table result or a behavioral conversion that
// walks its own copy of the lunar year table. Both sides insert random idle cycles.
// ============================================================================
module tb_gregorian_to_lunar_date;
    import gtl_pkg::*;

    localparam int  RANDOM_DATES   = 1600;
    localparam int  MAX_IDLE       = 18;
    localparam int  IDLE_PHASE     = 64;
    localparam int  DRAIN_CYCLES   = 300;
    localparam int  WATCHDOG_LIMIT = 5000;
    localparam int  NUM_DIRECTED   = 25;
    localparam bit  PREDICTED      = 1'b0;
    localparam bit  TYPED          = 1'b1;

    localparam lunar_res_t RES_INVALID = '{STATUS_INVALID, '0, '0, '0, 1'b0};
    localparam lunar_res_t RES_RANGE   = '{STATUS_RANGE, '0, '0, '0, 1'b0};

    // One row of the directed table; the result is used only on typed rows.
    typedef struct packed {
        logic [GYEAR_W-1:0]  year;
        logic [GMONTH_W-1:0] month;
        logic [GDAY_W-1:0]   day;
        logic                typed;
        lunar_res_t          result;
    } date_row_t;

    // One expected word, with the date that caused it for messages.
    typedef struct {
        logic [GYEAR_W-1:0]  year;
        logic [GMONTH_W-1:0] month;
        logic [GDAY_W-1:0]   day;
        lunar_res_t          result;
    } lunar_expect_t;

    localparam date_row_t DIRECTED_DATES [NUM_DIRECTED] = '{
        '{12'd1939, 4'd2,  5'd19, TYPED, '{STATUS_OK, 11'd1939, 4'd1, 5'd1, 1'b0}},
        '{12'd1939, 4'd2,  5'd20, TYPED, '{STATUS_OK, 11'd1939, 4'd1, 5'd2, 1'b0}},
        '{12'd1939, 4'd2,  5'd18, TYPED, RES_RANGE},
        '{12'd1939, 4'd1,  5'd1,  TYPED, RES_RANGE},
        '{12'd1938, 4'd12, 5'd31, TYPED, RES_INVALID},
        '{12'd2042, 4'd1,  5'd1,  TYPED, RES_INVALID},
        '{12'd0,    4'd0,  5'd0,  TYPED, RES_INVALID},
        '{12'd4095, 4'd15, 5'd31, TYPED, RES_INVALID},
        '{12'd2000, 4'd0,  5'd10, TYPED, RES_INVALID},
        '{12'd2000, 4'd13, 5'd10, TYPED, RES_INVALID},
        '{12'd2000, 4'd1,  5'd0,  TYPED, RES_INVALID},
        '{12'd2000, 4'd4,  5'd31, TYPED, RES_INVALID},
        '{12'd2001, 4'd2,  5'd29, TYPED, RES_INVALID},
        '{12'd1939, 4'd2,  5'd29, TYPED, RES_INVALID},
        '{12'd2000, 4'd2,  5'd29, PREDICTED, '0},
        '{12'd2041, 4'd12, 5'd31, PREDICTED, '0},
        '{12'd2041, 4'd1,  5'd31, PREDICTED, '0},
        '{12'd1939, 4'd12, 5'd31, PREDICTED, '0},
        '{12'd1984, 4'd2,  5'd2,  PREDICTED, '0},
        '{12'd2020, 4'd5,  5'd23, PREDICTED, '0},
        '{12'd2020, 4'd6,  5'd20, PREDICTED, '0},
        '{12'd2020, 4'd6,  5'd21, PREDICTED, '0},
        '{12'd2023, 4'd4,  5'd19, PREDICTED, '0},
        '{12'd2033, 4'd12, 5'd22, PREDICTED, '0},
        '{12'd2034, 4'd1,  5'd19, PREDICTED, '0}
    };

    // Lunar year codes from the first lunar year on: month sizes in bits
    // 15..4, leap month number in bits 3..0, leap month size in bit 16.
    localparam logic [WORD_W-1:0] lunar_year_code [ROM_SIZE] = '{
        20'h0c950,
        20'h0d4a0, 20'h1d8a6, 20'h0b550, 20'h056a0, 20'h1a5b4,
        20'h025d0, 20'h092d0, 20'h0d2b2, 20'h0a950, 20'h0b557,
        20'h06ca0, 20'h0b550, 20'h15355, 20'h04da0, 20'h0a5d0,
        20'h14573, 20'h052d0, 20'h0a9a8, 20'h0e950, 20'h06aa0,
        20'h0aea6, 20'h0ab50, 20'h04b60, 20'h0aae4, 20'h0a570,
        20'h05260, 20'h0f263, 20'h0d950, 20'h05b57, 20'h056a0,
        20'h096d0, 20'h04dd5, 20'h04ad0, 20'h0a4d0, 20'h0d4d4,
        20'h0d250, 20'h0d558, 20'h0b540, 20'h0b5a0, 20'h195a6,
        20'h095b0, 20'h049b0, 20'h0a974, 20'h0a4b0, 20'h0b27a,
        20'h06a50, 20'h06d40, 20'h0af46, 20'h0ab60, 20'h09570,
        20'h04af5, 20'h04970, 20'h064b0, 20'h074a3, 20'h0ea50,
        20'h06b58, 20'h055c0, 20'h0ab60, 20'h096d5, 20'h092e0,
        20'h0c960, 20'h0d954, 20'h0d4a0, 20'h0da50, 20'h07552,
        20'h056a0, 20'h0abb7, 20'h025d0, 20'h092d0, 20'h0cab5,
        20'h0a950, 20'h0b4a0, 20'h0baa4, 20'h0ad50, 20'h055d9,
        20'h04ba0, 20'h0a5b0, 20'h15176, 20'h052b0, 20'h0a930,
        20'h07954, 20'h06aa0, 20'h0ad50, 20'h05b52, 20'h04b60,
        20'h0a6e6, 20'h0a4e0, 20'h0d260, 20'h0ea65, 20'h0d530,
        20'h05aa0, 20'h076a3, 20'h096d0, 20'h04bd7, 20'h04ad0,
        20'h0a4d0, 20'h1d0b6, 20'h0d250, 20'h0d520, 20'h0dd45,
        20'h0b5a0, 20'h056d0, 20'h055b2, 20'h049b0, 20'h0a577,
        20'h0a4b0, 20'h0aa50, 20'h1b255, 20'h06d20, 20'h0ada0
    };

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [GYEAR_W-1:0]  s_greg_year = '0;
    logic [GMONTH_W-1:0] s_greg_month = '0;
    logic [GDAY_W-1:0]   s_greg_day = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [LYEAR_W-1:0]  m_lunar_year;
    logic [LMONTH_W-1:0] m_lunar_month;
    logic [LDAY_W-1:0]   m_lunar_day;
    logic                m_is_leap_month;

    lunar_expect_t lunar_expect_q[$];
    int            mismatch_count = 0;
    int            quiet_cycles = 0;
    bit            send_idle = 1'b1;
    bit            take_idle = 1'b1;

    gregorian_to_lunar_date dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_greg_year     (s_greg_year),
        .s_greg_month    (s_greg_month),
        .s_greg_day      (s_greg_day),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_lunar_year    (m_lunar_year),
        .m_lunar_month   (m_lunar_month),
        .m_lunar_day     (m_lunar_day),
        .m_is_leap_month (m_is_leap_month)
    );

    // Clock with a 2 ns period.
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic bit greg_is_leap(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int greg_month_len(input int y, input int m);
        int n;
        case (m)
            2:             n = greg_is_leap(y) ? 29 : 28;
            4, 6, 9, 11:   n = 30;
            default:       n = 31;
        endcase
        return n;
    endfunction

    // Converts one date: count days from the start of the first year, move
    // to the first lunar new year, then walk whole lunar years and months.
    function automatic lunar_res_t predict_lunar_date(input logic [GYEAR_W-1:0] y,
                                                      input logic [GMONTH_W-1:0] mo,
                                                      input logic [GDAY_W-1:0] d);
        lunar_res_t  res;
        int          days;
        int          i;
        int          idx;
        int          m;
        int          yr_len;
        int          mlen;
        int          leap_no;
        logic [WORD_W-1:0] code;
        res = RES_INVALID;
        if (int'(y) < FIRST_YEAR || int'(y) > LAST_GREG_YEAR || mo < 1 || mo > 12 ||
            d < 1 || int'(d) > greg_month_len(int'(y), int'(mo))) begin
            return res;
        end
        days = 0;
        for (i = FIRST_YEAR; i < int'(y); i++) begin
            days += greg_is_leap(i) ? 366 : 365;
        end
        for (i = 1; i < int'(mo); i++) begin
            days += greg_month_len(int'(y), i);
        end
        days += int'(d) - 1;
        res = RES_RANGE;
        if (days <= NEW_YEAR_OFFSET) begin
            return res;
        end
        days -= NEW_YEAR_OFFSET;
        for (idx = 0; idx < TABLE_YEARS_DEF && idx < ROM_SIZE; idx++) begin
            code    = lunar_year_code[idx];
            leap_no = int'(code[3:0]);
            yr_len  = 0;
            for (m = 1; m <= 12; m++) begin
                yr_len += code[16 - m] ? 30 : 29;
            end
            if (leap_no != 0) begin
                yr_len += code[16] ? 30 : 29;
            end
            if (days > yr_len) begin
                days -= yr_len;
                continue;
            end
            // The day lies in this lunar year; the leap month follows its
            // ordinary month and keeps its own last day.
            for (m = 1; m <= 12; m++) begin
                mlen = code[16 - m] ? 30 : 29;
                if (days <= mlen) begin
                    res = '{STATUS_OK, LYEAR_W'(FIRST_YEAR + idx), LMONTH_W'(m),
                            LDAY_W'(days), 1'b0};
                    return res;
                end
                days -= mlen;
                if (leap_no == m) begin
                    mlen = code[16] ? 30 : 29;
                    if (days <= mlen) begin
                        res = '{STATUS_OK, LYEAR_W'(FIRST_YEAR + idx), LMONTH_W'(m),
                                LDAY_W'(days), 1'b1};
                        return res;
                    end
                    days -= mlen;
                end
            end
            return res;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Presents one date word after a random gap and records what it must
    // produce once the block has taken it.
    task automatic post_date(input logic [GYEAR_W-1:0] y, input logic [GMONTH_W-1:0] mo,
                             input logic [GDAY_W-1:0] d, input bit typed,
                             input lunar_res_t typed_res);
        int            gap;
        lunar_expect_t entry;
        gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_greg_year  <= y;
        s_greg_month <= mo;
        s_greg_day   <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        entry.year   = y;
        entry.month  = mo;
        entry.day    = d;
        entry.result = typed ? typed_res : predict_lunar_date(y, mo, d);
        lunar_expect_q.push_back(entry);
    endtask

    // Result side: random stalls before each word, then a field by field
    // check against the oldest expected word.
    initial begin
        int            stall;
        int            taken;
        lunar_expect_t want;
        string         tag;
        taken = 0;
        wait (aresetn);
        forever begin
            if (taken % IDLE_PHASE == 0) begin
                take_idle = ($urandom_range(0, 3) != 0);
            end
            stall = take_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
            if (lunar_expect_q.size() == 0) begin
                report_mismatch("result word with no date outstanding");
            end else begin
                want = lunar_expect_q.pop_front();
                tag  = $sformatf("%0d-%0d-%0d", want.year, want.month, want.day);
                if (m_status !== want.result.status)
                    report_mismatch($sformatf("%s status %0d, want %0d", tag,
                                              m_status, want.result.status));
                if (m_lunar_year !== want.result.lunar_year)
                    report_mismatch($sformatf("%s lunar_year %0d, want %0d", tag,
                                              m_lunar_year, want.result.lunar_year));
                if (m_lunar_month !== want.result.lunar_month)
                    report_mismatch($sformatf("%s lunar_month %0d, want %0d", tag,
                                              m_lunar_month, want.result.lunar_month));
                if (m_lunar_day !== want.result.lunar_day)
                    report_mismatch($sformatf("%s lunar_day %0d, want %0d", tag,
                                              m_lunar_day, want.result.lunar_day));
                if (m_is_leap_month !== want.result.is_leap_month)
                    report_mismatch($sformatf("%s is_leap_month %0d, want %0d", tag,
                                              m_is_leap_month,
                                              want.result.is_leap_month));
            end
        end
    end

    // Watchdog: ends the run when neither channel moves a word for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random dates, drain.
    initial begin
        int                  n;
        int                  kind;
        logic [GYEAR_W-1:0]  y;
        logic [GMONTH_W-1:0] mo;
        logic [GDAY_W-1:0]   d;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (n = 0; n < NUM_DIRECTED; n++) begin
            post_date(DIRECTED_DATES[n].year, DIRECTED_DATES[n].month,
                      DIRECTED_DATES[n].day, DIRECTED_DATES[n].typed,
                      DIRECTED_DATES[n].result);
        end

        for (n = 0; n < RANDOM_DATES; n++) begin
            if (n % IDLE_PHASE == 0) begin
                send_idle = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 99);
            y  = GYEAR_W'($urandom_range(FIRST_YEAR, LAST_GREG_YEAR));
            mo = GMONTH_W'($urandom_range(1, 12));
            if (kind < 65) begin
                // Any valid date.
                d = GDAY_W'($urandom_range(1, greg_month_len(int'(y), int'(mo))));
            end else if (kind < 78) begin
                // Around the lunar new year, where the year walk turns over.
                mo = GMONTH_W'($urandom_range(1, 2));
                d  = GDAY_W'($urandom_range(1, greg_month_len(int'(y), int'(mo))));
            end else if (kind < 83) begin
                // Start of the range, before and after the first new year.
                y  = GYEAR_W'(FIRST_YEAR);
                mo = GMONTH_W'($urandom_range(1, 3));
                d  = GDAY_W'($urandom_range(1, greg_month_len(int'(y), int'(mo))));
            end else if (kind < 90) begin
                // Last day of a month, or one past it.
                d = GDAY_W'(greg_month_len(int'(y), int'(mo)) + $urandom_range(0, 1));
            end else begin
                // Raw noise over every bit of every field.
                y  = GYEAR_W'($urandom);
                mo = GMONTH_W'($urandom);
                d  = GDAY_W'($urandom);
            end
            post_date(y, mo, d, PREDICTED, '0);
        end
        s_valid <= 1'b0;

        while (lunar_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
